>>> hw/rtl/rsnh_pkg.sv
// Package for the ray/sphere nearest-hit block: widths, codes, shared types.
// Used by every file of the block but rsnh_ram; depends on nothing.
package rsnh_pkg;

  // Fixed point and store geometry.
  localparam int FRAC_BITS   = 12;
  localparam int RAY_SLOTS   = 4096;
  localparam int SLOT_W      = $clog2(RAY_SLOTS);
  localparam int COORD_W     = 16;
  localparam int DIST_W      = 20;
  localparam int ID_W        = 16;
  localparam int SID_W       = 15;
  localparam int RAD_W       = 15;

  // Arithmetic widths of the front pipeline.
  localparam int OC_W        = COORD_W + 1;
  localparam int DOT_W       = 2 * OC_W + 1;
  localparam int HB_W        = DOT_W - FRAC_BITS;
  localparam int SQ_W        = 2 * OC_W;
  localparam int C_W         = SQ_W + 2;
  localparam int HB2_W       = 2 * HB_W;
  localparam int DISC_W      = HB2_W + 1;
  localparam int ROOT_W      = HB2_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int T_W         = HB_W + 2;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 32;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_ID = 3'd4;

  // Commands.
  localparam logic CMD_CLEAR     = 1'b0;
  localparam logic CMD_INTERSECT = 1'b1;

  // Store codes.
  localparam logic [DIST_W-1:0] NO_HIT_DIST = '1;
  localparam logic [DIST_W-1:0] MAX_DIST    = NO_HIT_DIST - DIST_W'(1);
  localparam logic [ID_W-1:0]   NO_HIT_ID   = '1;
  localparam logic [RAD_W-1:0]  RADIUS_RST  = RAD_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
    logic [SID_W-1:0]          sphere_id;
  } cfg_t;

  typedef struct packed {
    logic                      command;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } in_word_t;

  // Sideband carried along the square-root stages.
  typedef struct packed {
    logic                   command;
    logic [SLOT_W-1:0]      slot;
    logic                   neg;
    logic signed [HB_W-1:0] hb;
  } side_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic              cand;
    logic [DIST_W-1:0] distance;
  } job_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

>>> hw/rtl/rsnh_ifs.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on rsnh_pkg for field widths.
interface rsnh_in_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic [rsnh_pkg::SLOT_W-1:0]        ray_index;
  logic signed [rsnh_pkg::COORD_W-1:0] origin_x;
  logic signed [rsnh_pkg::COORD_W-1:0] origin_y;
  logic signed [rsnh_pkg::COORD_W-1:0] origin_z;
  logic signed [rsnh_pkg::COORD_W-1:0] dir_x;
  logic signed [rsnh_pkg::COORD_W-1:0] dir_y;
  logic signed [rsnh_pkg::COORD_W-1:0] dir_z;

  modport source (output valid, command, ray_index, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, command, ray_index, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, output ready);
endinterface

interface rsnh_out_if;
  logic                             valid;
  logic                             ready;
  logic [rsnh_pkg::SLOT_W-1:0]      out_ray_index;
  logic [rsnh_pkg::DIST_W-1:0]      nearest_distance;
  logic signed [rsnh_pkg::ID_W-1:0] nearest_id;
  logic                             hit_now;

  modport source (output valid, out_ray_index, nearest_distance, nearest_id, hit_now,
                  input ready);
  modport sink (input valid, out_ray_index, nearest_distance, nearest_id, hit_now,
                output ready);
endinterface

>>> hw/rtl/rsnh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; a read of the address being written returns the old data.
module rsnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/rsnh_front.sv
// Front pipeline: takes each word, solves the ray/sphere quadratic and
// classifies it into a job for the store. Depends on rsnh_pkg.
module rsnh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  rsnh_pkg::in_word_t in_word,
  input  rsnh_pkg::cfg_t     cfg,
  output logic               job_valid,
  output rsnh_pkg::job_t     job
);

  localparam int STEPS = rsnh_pkg::ROOT_W;

  // Stage 1: offset from the centre.
  logic                                v1_r;
  logic                                cmd1_r;
  logic [rsnh_pkg::SLOT_W-1:0]         slot1_r;
  logic signed [rsnh_pkg::OC_W-1:0]    ocx1_r, ocy1_r, ocz1_r;
  logic signed [rsnh_pkg::COORD_W-1:0] dx1_r, dy1_r, dz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
    cmd1_r  <= in_word.command;
    slot1_r <= in_word.slot;
    ocx1_r  <= $signed({in_word.origin_x[rsnh_pkg::COORD_W-1], in_word.origin_x})
             - $signed({cfg.center_x[rsnh_pkg::COORD_W-1], cfg.center_x});
    ocy1_r  <= $signed({in_word.origin_y[rsnh_pkg::COORD_W-1], in_word.origin_y})
             - $signed({cfg.center_y[rsnh_pkg::COORD_W-1], cfg.center_y});
    ocz1_r  <= $signed({in_word.origin_z[rsnh_pkg::COORD_W-1], in_word.origin_z})
             - $signed({cfg.center_z[rsnh_pkg::COORD_W-1], cfg.center_z});
    dx1_r   <= in_word.dir_x;
    dy1_r   <= in_word.dir_y;
    dz1_r   <= in_word.dir_z;
  end

  // Stage 2: products for the dot product, the squared length and r squared.
  logic                                    v2_r;
  logic                                    cmd2_r;
  logic [rsnh_pkg::SLOT_W-1:0]             slot2_r;
  logic signed [rsnh_pkg::DOT_W-2:0]       pdx2_r, pdy2_r, pdz2_r;
  logic signed [rsnh_pkg::SQ_W-1:0]        sqx2_r, sqy2_r, sqz2_r;
  logic [2*rsnh_pkg::RAD_W-1:0]            rr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cmd2_r  <= cmd1_r;
    slot2_r <= slot1_r;
    pdx2_r  <= ocx1_r * dx1_r;
    pdy2_r  <= ocy1_r * dy1_r;
    pdz2_r  <= ocz1_r * dz1_r;
    sqx2_r  <= ocx1_r * ocx1_r;
    sqy2_r  <= ocy1_r * ocy1_r;
    sqz2_r  <= ocz1_r * ocz1_r;
    rr2_r   <= cfg.radius * cfg.radius;
  end

  // Stage 3: half_b as the floored dot product, and c.
  logic signed [rsnh_pkg::DOT_W-1:0] dot_sum;
  logic signed [rsnh_pkg::DOT_W-1:0] dot_fl;
  logic signed [rsnh_pkg::C_W-1:0]   c_val;
  logic                              v3_r;
  logic                              cmd3_r;
  logic [rsnh_pkg::SLOT_W-1:0]       slot3_r;
  logic signed [rsnh_pkg::HB_W-1:0]  hb3_r;
  logic signed [rsnh_pkg::C_W-1:0]   c3_r;

  assign dot_sum = pdx2_r + pdy2_r + pdz2_r;
  assign dot_fl  = dot_sum >>> rsnh_pkg::FRAC_BITS;
  assign c_val   = sqx2_r + sqy2_r + sqz2_r
                 - $signed({{(rsnh_pkg::C_W - 2*rsnh_pkg::RAD_W){1'b0}}, rr2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    cmd3_r  <= cmd2_r;
    slot3_r <= slot2_r;
    hb3_r   <= dot_fl[rsnh_pkg::HB_W-1:0];
    c3_r    <= c_val;
  end

  // Stage 4: half_b squared.
  logic                              v4_r;
  logic                              cmd4_r;
  logic [rsnh_pkg::SLOT_W-1:0]       slot4_r;
  logic signed [rsnh_pkg::HB_W-1:0]  hb4_r;
  logic signed [rsnh_pkg::HB2_W-1:0] hb2_4_r;
  logic signed [rsnh_pkg::C_W-1:0]   c4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    cmd4_r  <= cmd3_r;
    slot4_r <= slot3_r;
    hb4_r   <= hb3_r;
    hb2_4_r <= hb3_r * hb3_r;
    c4_r    <= c3_r;
  end

  // Discriminant, loaded into the first square-root stage.
  logic signed [rsnh_pkg::DISC_W-1:0] disc;
  assign disc = hb2_4_r - c4_r;

  logic                          sq_v_r    [0:STEPS];
  rsnh_pkg::side_t               sq_side_r [0:STEPS];
  logic [rsnh_pkg::REM_W-1:0]    sq_rem_r  [0:STEPS];
  logic [rsnh_pkg::ROOT_W-1:0]   sq_root_r [0:STEPS];
  logic [rsnh_pkg::HB2_W-1:0]    sq_x_r    [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= v4_r;
    end
    sq_side_r[0].command <= cmd4_r;
    sq_side_r[0].slot    <= slot4_r;
    sq_side_r[0].neg     <= disc[rsnh_pkg::DISC_W-1];
    sq_side_r[0].hb      <= hb4_r;
    sq_rem_r[0]          <= '0;
    sq_root_r[0]         <= '0;
    sq_x_r[0]            <= disc[rsnh_pkg::HB2_W-1:0];
  end

  // Square root, one result bit per stage (restoring digit recurrence).
  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    logic [rsnh_pkg::REM_W-1:0] rem_sh;
    logic [rsnh_pkg::REM_W-1:0] trial;
    logic                       ge;

    assign rem_sh = {sq_rem_r[k][rsnh_pkg::REM_W-3:0],
                     sq_x_r[k][rsnh_pkg::HB2_W-1 -: 2]};
    assign trial  = {1'b0, sq_root_r[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      sq_side_r[k+1] <= sq_side_r[k];
      sq_rem_r[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
      sq_root_r[k+1] <= {sq_root_r[k][rsnh_pkg::ROOT_W-2:0], ge};
      sq_x_r[k+1]    <= {sq_x_r[k][rsnh_pkg::HB2_W-3:0], 2'b00};
    end
  end

  // Final stage: near root, range checks and saturation.
  rsnh_pkg::side_t               fin;
  logic signed [rsnh_pkg::T_W-1:0] hb_w;
  logic signed [rsnh_pkg::T_W-1:0] root_w;
  logic signed [rsnh_pkg::T_W-1:0] t_val;
  logic                          t_big;
  logic                          job_valid_r;
  rsnh_pkg::job_t                job_r;

  assign fin    = sq_side_r[STEPS];
  assign hb_w   = fin.hb;
  assign root_w = $signed({2'b00, sq_root_r[STEPS]});
  assign t_val  = -hb_w - root_w;
  assign t_big  = (t_val > $signed({{(rsnh_pkg::T_W - rsnh_pkg::DIST_W){1'b0}},
                                    rsnh_pkg::MAX_DIST}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= sq_v_r[STEPS];
    end
    job_r.command  <= fin.command;
    job_r.slot     <= fin.slot;
    job_r.cand     <= (fin.command == rsnh_pkg::CMD_INTERSECT) && !fin.neg
                    && !t_val[rsnh_pkg::T_W-1];
    job_r.distance <= t_big ? rsnh_pkg::MAX_DIST : t_val[rsnh_pkg::DIST_W-1:0];
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

>>> hw/rtl/rsnh_queue.sv
// Short job queue between the front pipeline and the store back end.
// Register-file FIFO; depends on rsnh_pkg.
module rsnh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsnh_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output rsnh_pkg::job_t head_job
);

  rsnh_pkg::job_t                 slot_r [rsnh_pkg::QUEUE_DEPTH];
  logic [rsnh_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [rsnh_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [rsnh_pkg::QUEUE_AW:0]    count_r;
  logic [rsnh_pkg::QUEUE_AW:0]    count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < (rsnh_pkg::QUEUE_AW+1)'(rsnh_pkg::QUEUE_DEPTH)))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("job queue popped while empty");
`endif

endmodule

>>> hw/rtl/rsnh_back.sv
// Back end: clears the hit store after reset, then applies each job to the
// store with a read-modify-write and registers the result word.
// Depends on rsnh_pkg, rsnh_ram and the rsnh_out_if interface.
module rsnh_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rsnh_pkg::SID_W-1:0]    sphere_id,
  input  logic                          q_valid,
  input  rsnh_pkg::job_t                q_job,
  output rsnh_pkg::back_stat_t          stat,
  rsnh_out_if.source                    out_ch
);

  // Clearing pass state.
  logic [rsnh_pkg::SLOT_W:0] clr_cnt_r;
  logic                      clearing;
  assign clearing = (clr_cnt_r < (rsnh_pkg::SLOT_W+1)'(rsnh_pkg::RAY_SLOTS));

  // Handshake of the back pipeline.
  logic out_valid_r;
  logic adv;
  logic pop;
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && q_valid && !clearing;

  // Store read stage and last write seen, for read-after-write forwarding.
  logic                        b2_v_r;
  rsnh_pkg::job_t              b2_job_r;
  logic                        lw_v_r;
  logic [rsnh_pkg::SLOT_W-1:0] lw_addr_r;
  rsnh_pkg::entry_t            lw_data_r;
  rsnh_pkg::entry_t            ram_rdata;

  rsnh_pkg::entry_t cur;
  rsnh_pkg::entry_t upd;
  logic             hit;

  always_comb begin
    cur = (lw_v_r && (lw_addr_r == b2_job_r.slot)) ? lw_data_r : ram_rdata;
    upd = cur;
    hit = 1'b0;
    if (b2_job_r.command == rsnh_pkg::CMD_CLEAR) begin
      upd.distance = rsnh_pkg::NO_HIT_DIST;
      upd.id       = rsnh_pkg::NO_HIT_ID;
    end else if (b2_job_r.cand && (b2_job_r.distance < cur.distance)) begin
      upd.distance = b2_job_r.distance;
      upd.id       = {1'b0, sphere_id};
      hit          = 1'b1;
    end
  end

  // Store write port: clearing pass first, then job updates.
  logic                        ram_we;
  logic [rsnh_pkg::SLOT_W-1:0] ram_waddr;
  rsnh_pkg::entry_t            ram_wdata;

  always_comb begin
    ram_we    = b2_v_r && adv;
    ram_waddr = b2_job_r.slot;
    ram_wdata = upd;
    if (clearing) begin
      ram_we             = 1'b1;
      ram_waddr          = clr_cnt_r[rsnh_pkg::SLOT_W-1:0];
      ram_wdata.distance = rsnh_pkg::NO_HIT_DIST;
      ram_wdata.id       = rsnh_pkg::NO_HIT_ID;
    end
  end

  rsnh_ram #(
    .WIDTH ($bits(rsnh_pkg::entry_t)),
    .DEPTH (rsnh_pkg::RAY_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_job.slot),
    .rdata (ram_rdata)
  );

  // Output word register.
  logic [rsnh_pkg::SLOT_W-1:0] out_slot_r;
  rsnh_pkg::entry_t            out_entry_r;
  logic                        out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      b2_v_r      <= 1'b0;
      lw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (adv) begin
        b2_v_r      <= pop;
        out_valid_r <= b2_v_r;
        if (b2_v_r) begin
          lw_v_r <= 1'b1;
        end
      end
    end
    if (pop) begin
      b2_job_r <= q_job;
    end
    if (adv && b2_v_r) begin
      lw_addr_r   <= b2_job_r.slot;
      lw_data_r   <= upd;
      out_slot_r  <= b2_job_r.slot;
      out_entry_r <= upd;
      out_hit_r   <= hit;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_ray_index    = out_slot_r;
  assign out_ch.nearest_distance = out_entry_r.distance;
  assign out_ch.nearest_id       = out_entry_r.id;
  assign out_ch.hit_now          = out_hit_r;

  assign stat.pop      = pop;
  assign stat.clearing = clearing;

`ifndef SYNTHESIS
  a_hit_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_entry_r.distance != rsnh_pkg::NO_HIT_DIST))
    else $error("hit reported with no-hit distance");
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!b2_v_r && !out_valid_r))
    else $error("job in flight during clearing pass");
`endif

endmodule

>>> hw/rtl/ray_sphere_nearest_hit.sv
// Ray/sphere nearest-hit block, top level: configuration registers, credit
// control, front pipeline, job queue and store back end.
// Depends on rsnh_pkg, rsnh_ifs, rsnh_front, rsnh_queue and rsnh_back.
//
// Usage: words arrive on in_ch (valid/ready). Command intersect solves the
// ray against the configured sphere and keeps the nearest hit per ray slot;
// command clear returns the slot to no hit. Every word gives one result word
// on out_ch with the slot's entry after the update and a hit_now flag.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Throughput: one word per cycle while in_ch.ready is high. From acceptance
// to the result word a word passes 4 arithmetic stages, the discriminant
// stage, 23 square-root stages (one root bit per stage), the classify stage,
// the queue, the store read and the output register.
// After reset the store is swept to no hit, one slot per cycle, over all 4096
// slots; in_ch.ready stays low meanwhile, configuration writes are taken.
// When the receiver stalls, jobs collect in the 32-word queue and in_ch.ready
// drops once 32 words are accepted but not yet taken by the back end.
module ray_sphere_nearest_hit (
  input  logic                               clk,
  input  logic                               rst_n,
  rsnh_in_if.sink                            in_ch,
  rsnh_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rsnh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsnh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers.
  rsnh_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x  <= '0;
      cfg_r.center_y  <= '0;
      cfg_r.center_z  <= '0;
      cfg_r.radius    <= rsnh_pkg::RADIUS_RST;
      cfg_r.sphere_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsnh_pkg::CFG_CENTER_X:  cfg_r.center_x  <= cfg_data;
        rsnh_pkg::CFG_CENTER_Y:  cfg_r.center_y  <= cfg_data;
        rsnh_pkg::CFG_CENTER_Z:  cfg_r.center_z  <= cfg_data;
        rsnh_pkg::CFG_RADIUS:    cfg_r.radius    <= cfg_data[rsnh_pkg::RAD_W-1:0];
        rsnh_pkg::CFG_SPHERE_ID: cfg_r.sphere_id <= cfg_data[rsnh_pkg::SID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Credits: words accepted but not yet taken by the back end.
  rsnh_pkg::back_stat_t        stat;
  logic [rsnh_pkg::QUEUE_AW:0] credit_r;
  logic [rsnh_pkg::QUEUE_AW:0] credit_nxt;
  logic                        in_fire;

  assign in_ch.ready = !stat.clearing
                     && (credit_r < (rsnh_pkg::QUEUE_AW+1)'(rsnh_pkg::QUEUE_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    credit_nxt = credit_r;
    if (in_fire && !stat.pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (stat.pop && !in_fire) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Input word.
  rsnh_pkg::in_word_t in_word;
  assign in_word.command  = in_ch.command;
  assign in_word.slot     = in_ch.ray_index;
  assign in_word.origin_x = in_ch.origin_x;
  assign in_word.origin_y = in_ch.origin_y;
  assign in_word.origin_z = in_ch.origin_z;
  assign in_word.dir_x    = in_ch.dir_x;
  assign in_word.dir_y    = in_ch.dir_y;
  assign in_word.dir_z    = in_ch.dir_z;

  logic           job_valid;
  rsnh_pkg::job_t job;
  logic           q_valid;
  rsnh_pkg::job_t q_job;

  rsnh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (job)
  );

  rsnh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_job   (job),
    .pop        (stat.pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  rsnh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sphere_id (cfg_r.sphere_id),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .stat      (stat),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= (rsnh_pkg::QUEUE_AW+1)'(rsnh_pkg::QUEUE_DEPTH))
    else $error("credit count above queue depth");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for ray_sphere_nearest_hit: streams intersect and clear words
// through random stalls on both channels and checks every result word.
// Depends on rsnh_pkg, rsnh_ifs and the block's RTL.
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [rsnh_pkg::SLOT_W-1:0] slot;
    logic [rsnh_pkg::DIST_W-1:0] distance;
    logic [rsnh_pkg::ID_W-1:0]   id;
    logic                        hit;
  } hit_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rsnh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rsnh_pkg::CFG_DATA_W-1:0] cfg_data;

  rsnh_in_if  in_if ();
  rsnh_out_if out_if ();

  ray_sphere_nearest_hit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our copy of the sphere settings and of the per-ray hit store.
  logic signed [rsnh_pkg::COORD_W-1:0] sph_cx, sph_cy, sph_cz;
  logic [rsnh_pkg::RAD_W-1:0] sph_radius;
  logic [rsnh_pkg::SID_W-1:0] sph_id;
  logic [rsnh_pkg::DIST_W-1:0] store_dist [rsnh_pkg::RAY_SLOTS];
  logic [rsnh_pkg::ID_W-1:0]   store_id [rsnh_pkg::RAY_SLOTS];

  rsnh_pkg::in_word_t pending_rays[$];
  hit_report_t        expected_reports[$];

  int  errors = 0;
  int  accepted_words = 0;
  int  checked_words = 0;
  int  hit_words = 0;
  bit  calm_phase = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  long_hold = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Applies one word to the store copy and returns the report it should give.
  function automatic hit_report_t nearest_hit_update(rsnh_pkg::in_word_t w);
    hit_report_t rep;
    longint ocx, ocy, ocz, dot, hb, c, disc, t, r;
    rep.slot = w.slot;
    rep.hit = 1'b0;
    if (w.command == rsnh_pkg::CMD_CLEAR) begin
      store_dist[w.slot] = rsnh_pkg::NO_HIT_DIST;
      store_id[w.slot] = rsnh_pkg::NO_HIT_ID;
    end else begin
      ocx = longint'(w.origin_x) - longint'(sph_cx);
      ocy = longint'(w.origin_y) - longint'(sph_cy);
      ocz = longint'(w.origin_z) - longint'(sph_cz);
      r = longint'(sph_radius);
      dot = ocx * longint'(w.dir_x) + ocy * longint'(w.dir_y) + ocz * longint'(w.dir_z);
      hb = dot >>> rsnh_pkg::FRAC_BITS;
      c = ocx * ocx + ocy * ocy + ocz * ocz - r * r;
      disc = hb * hb - c;
      if (disc >= 0) begin
        t = -hb - longint'(int_sqrt(disc));
        if (t >= 0) begin
          if (t > longint'(rsnh_pkg::MAX_DIST)) t = longint'(rsnh_pkg::MAX_DIST);
          if (t < longint'(store_dist[w.slot])) begin
            store_dist[w.slot] = t[rsnh_pkg::DIST_W-1:0];
            store_id[w.slot] = rsnh_pkg::ID_W'(sph_id);
            rep.hit = 1'b1;
          end
        end
      end
    end
    rep.distance = store_dist[w.slot];
    rep.id = store_id[w.slot];
    return rep;
  endfunction

  function automatic rsnh_pkg::in_word_t ray_word(logic cmd, int slot, int ox, int oy,
                                                  int oz, int dx, int dy, int dz);
    rsnh_pkg::in_word_t w;
    w.command = cmd;
    w.slot = rsnh_pkg::SLOT_W'(slot);
    w.origin_x = rsnh_pkg::COORD_W'(ox);
    w.origin_y = rsnh_pkg::COORD_W'(oy);
    w.origin_z = rsnh_pkg::COORD_W'(oz);
    w.dir_x = rsnh_pkg::COORD_W'(dx);
    w.dir_y = rsnh_pkg::COORD_W'(dy);
    w.dir_z = rsnh_pkg::COORD_W'(dz);
    return w;
  endfunction

  // Random word: mostly rays aimed at the current sphere, with clears,
  // repeats for ties and fully random words as noise.
  function automatic rsnh_pkg::in_word_t random_ray(rsnh_pkg::in_word_t last);
    rsnh_pkg::in_word_t w;
    int pick, axis, off, dsign;
    int o[3];
    int d[3];
    int cen[3];
    pick = $urandom_range(0, 99);
    cen[0] = sph_cx;
    cen[1] = sph_cy;
    cen[2] = sph_cz;
    if (pick < 12) begin
      w = ray_word(rsnh_pkg::CMD_CLEAR, $urandom_range(0, 31), $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 25) begin
      w = ray_word($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
    end else if (pick < 33) begin
      w = last;
      w.command = rsnh_pkg::CMD_INTERSECT;
    end else begin
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        o[i] = cen[i] + $signed($urandom_range(0, 2400)) - 1200;
        d[i] = $signed($urandom_range(0, 600)) - 300;
      end
      off = $urandom_range(0, 6 * 4096);
      dsign = $urandom_range(0, 1) ? 1 : -1;
      o[axis] = cen[axis] - dsign * off;
      d[axis] = dsign * ($urandom_range(0, 9) == 0 ? -4096 : 4096);
      w = ray_word(rsnh_pkg::CMD_INTERSECT,
                   $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 31),
                   o[0], o[1], o[2], d[0], d[1], d[2]);
    end
    return w;
  endfunction

  // Sender: offers the oldest pending word, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
      in_if.valid <= 1'b1;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_reports.push_back(nearest_hit_update(pending_rays[0]));
        void'(pending_rays.pop_front());
        accepted_words++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 13) - 1;
        in_if.valid <= 1'b0;
      end else if (pending_rays.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.command <= pending_rays[0].command;
        in_if.ray_index <= pending_rays[0].slot;
        in_if.origin_x <= pending_rays[0].origin_x;
        in_if.origin_y <= pending_rays[0].origin_y;
        in_if.origin_z <= pending_rays[0].origin_z;
        in_if.dir_x <= pending_rays[0].dir_x;
        in_if.dir_y <= pending_rays[0].dir_y;
        in_if.dir_z <= pending_rays[0].dir_z;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts and, on request, one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_served < hold_requests) begin
      hold_served++;
      long_hold = 400;
      out_if.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
      recv_gap = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result word slot %0d", $time, out_if.out_ray_index);
        errors++;
      end else begin
        if (out_if.out_ray_index !== expected_reports[0].slot) begin
          $display("%0t: ray index expected %0d actual %0d", $time,
                   expected_reports[0].slot, out_if.out_ray_index);
          errors++;
        end
        if (out_if.nearest_distance !== expected_reports[0].distance) begin
          $display("%0t: distance expected %h actual %h", $time,
                   expected_reports[0].distance, out_if.nearest_distance);
          errors++;
        end
        if (out_if.nearest_id !== expected_reports[0].id) begin
          $display("%0t: id expected %h actual %h", $time,
                   expected_reports[0].id, out_if.nearest_id);
          errors++;
        end
        if (out_if.hit_now !== expected_reports[0].hit) begin
          $display("%0t: hit_now expected %b actual %b", $time,
                   expected_reports[0].hit, out_if.hit_now);
          errors++;
        end
        if (expected_reports[0].hit) hit_words++;
        void'(expected_reports.pop_front());
        checked_words++;
      end
    end
  end

  task automatic write_reg(logic [rsnh_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsnh_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      rsnh_pkg::CFG_CENTER_X:  sph_cx = value;
      rsnh_pkg::CFG_CENTER_Y:  sph_cy = value;
      rsnh_pkg::CFG_CENTER_Z:  sph_cz = value;
      rsnh_pkg::CFG_RADIUS:    sph_radius = value[rsnh_pkg::RAD_W-1:0];
      rsnh_pkg::CFG_SPHERE_ID: sph_id = value[rsnh_pkg::SID_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sphere(int cx, int cy, int cz, int r, int id);
    write_reg(rsnh_pkg::CFG_CENTER_X, rsnh_pkg::CFG_DATA_W'(cx));
    write_reg(rsnh_pkg::CFG_CENTER_Y, rsnh_pkg::CFG_DATA_W'(cy));
    write_reg(rsnh_pkg::CFG_CENTER_Z, rsnh_pkg::CFG_DATA_W'(cz));
    write_reg(rsnh_pkg::CFG_RADIUS, rsnh_pkg::CFG_DATA_W'(r));
    write_reg(rsnh_pkg::CFG_SPHERE_ID, rsnh_pkg::CFG_DATA_W'(id));
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || in_if.valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    rsnh_pkg::in_word_t last;
    last = ray_word(rsnh_pkg::CMD_INTERSECT, 0, 0, 0, -3 * 4096, 0, 0, 4096);
    for (int i = 0; i < count; i++) begin
      last = random_ray(last);
      pending_rays.push_back(last);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = rsnh_pkg::CMD_CLEAR;
    in_if.ray_index = '0;
    in_if.origin_x = '0;
    in_if.origin_y = '0;
    in_if.origin_z = '0;
    in_if.dir_x = '0;
    in_if.dir_y = '0;
    in_if.dir_z = '0;
    out_if.ready = 1'b0;
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_radius = rsnh_pkg::RADIUS_RST;
    sph_id = '0;
    for (int i = 0; i < rsnh_pkg::RAY_SLOTS; i++) begin
      store_dist[i] = rsnh_pkg::NO_HIT_DIST;
      store_id[i] = rsnh_pkg::NO_HIT_ID;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset sphere: unit sphere at the origin.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 0, 0, 0, -3 * 4096,
                                    0, 0, 4096));
    // Same ray again is a tie and must not replace the entry.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 0, 0, 0, -3 * 4096,
                                    0, 0, 4096));
    // A closer origin replaces it.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 0, 0, 0, -2 * 4096,
                                    0, 0, 4096));
    // Sphere behind the origin.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 1, 0, 0, 3 * 4096,
                                    0, 0, 4096));
    // Clean miss, offset sideways.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 1, 5 * 4096, 0, -3 * 4096,
                                    0, 0, 4096));
    // Origin inside the sphere gives a negative near root.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 2, 0, 0, 0, 4096, 0, 0));
    // Non-unit direction is used as given.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 3, 0, -4 * 4096, 0,
                                    0, 8192, 0));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 0, 0, 0, -3 * 4096,
                                    0, 0, 4096));
    // Hits from the extreme corners of the coordinate range.
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 4095, -32768, -32768, -32768,
                                    32767, 32767, 32767));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 4094, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 4093, -32768, 32767, -32768,
                                    32767, -32768, 32767));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 5, -1, -1, -1, -1, -1, -1));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 6, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_CLEAR, 4095, -1, -1, -1, -1, -1, -1));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_CLEAR, 7, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(ray_word(rsnh_pkg::CMD_INTERSECT, 4094, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
    drain();

    random_phase(150);

    // Long receiver hold-off while the sender keeps offering.
    set_sphere(4096, -8192, 12288, 8192, 32767);
    hold_requests++;
    random_phase(200);

    set_sphere(-32768, -32768, -32768, 0, 0);
    random_phase(150);

    set_sphere(32767, 32767, 32767, 32767 | 32768, 1 | 32768);
    random_phase(200);

    set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32767), $urandom);
    random_phase(200);

    // Final stretch without idling on either side.
    set_sphere(0, 0, 0, 4096, 12345);
    calm_phase = 1;
    random_phase(250);

    $display("Checked %0d result words of %0d accepted, %0d new nearest hits,",
             checked_words, accepted_words, hit_words);
    $display("over six sphere settings including extreme centers and radii.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rsnh_pkg.sv
hw/rtl/rsnh_ifs.sv
hw/rtl/rsnh_ram.sv
hw/rtl/rsnh_front.sv
hw/rtl/rsnh_queue.sv
hw/rtl/rsnh_back.sv
hw/rtl/ray_sphere_nearest_hit.sv
tb/sv/tb.sv
